### sv/rse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg - shared types and constants of the rpn stack evaluator
// operation codes, status codes, word structs and sequencer states
// ----------------------------------------------------------------------------
package rse_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int OP_W        = 5;
	localparam int DIV_CNT_W   = $clog2(DATA_WIDTH);

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH    = OP_W'(0);
	localparam logic [OP_W-1:0] OP_PLUS    = OP_W'(1);
	localparam logic [OP_W-1:0] OP_MINUS   = OP_W'(2);
	localparam logic [OP_W-1:0] OP_MULT    = OP_W'(3);
	localparam logic [OP_W-1:0] OP_DIV     = OP_W'(4);
	localparam logic [OP_W-1:0] OP_MOD     = OP_W'(5);
	localparam logic [OP_W-1:0] OP_LESS    = OP_W'(6);
	localparam logic [OP_W-1:0] OP_GREATER = OP_W'(7);
	localparam logic [OP_W-1:0] OP_EQUAL   = OP_W'(8);
	localparam logic [OP_W-1:0] OP_AND     = OP_W'(9);
	localparam logic [OP_W-1:0] OP_OR      = OP_W'(10);
	localparam logic [OP_W-1:0] OP_NOT     = OP_W'(11);
	localparam logic [OP_W-1:0] OP_NEG     = OP_W'(12);
	localparam logic [OP_W-1:0] OP_MAX     = OP_W'(13);
	localparam logic [OP_W-1:0] OP_MIN     = OP_W'(14);
	localparam logic [OP_W-1:0] OP_TRIPLE  = OP_W'(15);
	localparam logic [OP_W-1:0] OP_NUMPERC = OP_W'(16);
	localparam logic [OP_W-1:0] OP_PRINT   = OP_W'(17);

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	// divisor of the percent operation
	localparam logic [DATA_WIDTH-1:0] PERC_DIVISOR = DATA_WIDTH'(100);

	typedef struct packed {
		logic [OP_W-1:0]              op;
		logic signed [DATA_WIDTH-1:0] imm_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]                   status;
		logic signed [DATA_WIDTH-1:0] top_value;
		logic [CNT_W-1:0]             stack_count;
		logic                         print_valid;
		logic signed [DATA_WIDTH-1:0] print_value;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD_T,
		S_RD_N,
		S_DIV,
		S_FIX,
		S_MUL,
		S_WRITE,
		S_TOPW,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

### sv/rpn_stack_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_evaluator - integer rpn stack evaluator
// takes one instruction word, applies it to a 16-entry stack, returns one
// result word with status, top of stack, entry count and printed value
// ----------------------------------------------------------------------------
// each accepted instruction gives exactly one result word. the block works
// on one instruction at a time: cmd_ready is high only while the sequencer
// is idle. div, mod and numperc take longest, as they run through the
// radix-2 restoring divider, which retires one quotient bit per cycle. the
// stack lives in a small ram with one registered read port, so the top and
// next entries are fetched in successive cycles. a finished result sits in
// an output register, and the next instruction is taken while it waits; a
// new result stalls only if the previous one has still not been taken.
// underflow, overflow and divide by zero are reported in status and leave
// the stack unchanged. unknown op codes do nothing and report ok.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire rse_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_ready,
	output rse_pkg::res_t      res
);

	import rse_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_WIDTH - 1);
	localparam logic [CNT_W-1:0]     FULL     = CNT_W'(STACK_DEPTH);

	// sequencer state
	state_t state_q, state_d;

	// latched instruction
	logic [OP_W-1:0] op_q;
	logic [W-1:0]    imm_q;

	// stack pointer (entry count)
	logic [CNT_W-1:0] sp_q;

	// working registers
	logic [W-1:0] t_q;          // top operand
	logic [W-1:0] r_q;          // result of the operation
	logic [W-1:0] top_q;        // top of stack after the step
	logic [1:0]   status_q;
	logic         pv_q;
	logic [W-1:0] pval_q;

	// divider registers
	logic [W-1:0]         dvd_q;    // dividend, shifts into quotient
	logic [W-1:0]         dvs_q;
	logic [W-1:0]         rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 na_q;
	logic                 nb_q;

	// output register
	res_t res_q;
	logic res_valid_q;

	// ram ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [W-1:0]      ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [W-1:0]      ram_rdata;

	// stack addresses around the pointer
	logic [CNT_W-1:0] sp_m1, sp_m2;
	assign sp_m1 = sp_q - CNT_W'(1);
	assign sp_m2 = sp_q - CNT_W'(2);

	// instruction classes
	logic is_push, is_unary, is_binary, is_divop;
	assign is_push   = (op_q == OP_PUSH);
	assign is_unary  = (op_q == OP_NOT) || (op_q == OP_NEG) || (op_q == OP_TRIPLE)
		|| (op_q == OP_PRINT);
	assign is_binary = (op_q >= OP_PLUS) && (op_q <= OP_NUMPERC) && !is_unary;
	assign is_divop  = (op_q == OP_DIV) || (op_q == OP_MOD) || (op_q == OP_NUMPERC);

	logic out_free;
	assign out_free = !res_valid_q || res_ready;

	// shared multiplier: product for mult, then quotient times top for numperc
	logic [W-1:0]   mul_a;
	logic [2*W-1:0] mul_prod;
	assign mul_a    = (state_q == S_MUL) ? r_q : ram_rdata;
	assign mul_prod = mul_a * t_q;

	// unary result, top operand straight from the ram
	logic [W-1:0] un_res;
	always_comb begin
		case (op_q)
			OP_NOT:  un_res = {{(W-1){1'b0}}, (ram_rdata == '0)};
			OP_NEG:  un_res = '0 - ram_rdata;
			default: un_res = ram_rdata + {ram_rdata[W-2:0], 1'b0};
		endcase
	end

	// binary result, next operand straight from the ram
	logic [W-1:0] bin_res;
	logic         n_lt_t, t_lt_n;
	assign n_lt_t = $signed(ram_rdata) < $signed(t_q);
	assign t_lt_n = $signed(t_q) < $signed(ram_rdata);
	always_comb begin
		case (op_q)
			OP_PLUS:    bin_res = ram_rdata + t_q;
			OP_MINUS:   bin_res = ram_rdata - t_q;
			OP_MULT:    bin_res = mul_prod[W-1:0];
			OP_LESS:    bin_res = {{(W-1){1'b0}}, n_lt_t};
			OP_GREATER: bin_res = {{(W-1){1'b0}}, t_lt_n};
			OP_EQUAL:   bin_res = {{(W-1){1'b0}}, (ram_rdata == t_q)};
			OP_AND:     bin_res = {{(W-1){1'b0}}, (ram_rdata != '0) && (t_q != '0)};
			OP_OR:      bin_res = {{(W-1){1'b0}}, (ram_rdata != '0) || (t_q != '0)};
			OP_MAX:     bin_res = n_lt_t ? t_q : ram_rdata;
			OP_MIN:     bin_res = t_lt_n ? t_q : ram_rdata;
			default:    bin_res = '0;
		endcase
	end

	// one restoring step of the divider
	logic [W:0] trial;
	logic       q_bit;
	assign trial = {rem_q, dvd_q[W-1]} - {1'b0, dvs_q};
	assign q_bit = !trial[W];

	// sign fix of quotient and remainder
	logic [W-1:0] q_fix, r_fix;
	assign q_fix = (na_q ^ nb_q) ? ('0 - dvd_q) : dvd_q;
	assign r_fix = na_q ? ('0 - rem_q) : rem_q;

	// divide by zero seen when the next operand arrives
	logic div_zero;
	assign div_zero = ((op_q == OP_DIV) || (op_q == OP_MOD)) && (t_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (is_push && sp_q < FULL) state_d = S_DONE;
				else if (is_unary && sp_q >= CNT_W'(1)) state_d = S_RD_T;
				else if (is_binary && sp_q >= CNT_W'(2)) state_d = S_RD_T;
				else state_d = S_TOPW;
			end
			S_RD_T: begin
				if (op_q == OP_PRINT) state_d = S_TOPW;
				else if (is_unary) state_d = S_DONE;
				else state_d = S_RD_N;
			end
			S_RD_N: begin
				if (div_zero) state_d = S_DONE;
				else if (is_divop) state_d = S_DIV;
				else state_d = S_WRITE;
			end
			S_DIV: begin
				if (cnt_q == DIV_LAST) state_d = S_FIX;
			end
			S_FIX: begin
				state_d = (op_q == OP_NUMPERC) ? S_MUL : S_WRITE;
			end
			S_MUL:   state_d = S_WRITE;
			S_WRITE: state_d = S_DONE;
			S_TOPW:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = sp_q[ADDR_W-1:0];
		ram_wdata = imm_q;
		ram_raddr = sp_m1[ADDR_W-1:0];
		case (state_q)
			S_IDLE: cmd_ready = 1'b1;
			S_DECODE: begin
				// read the top while the class is checked
				ram_raddr = sp_m1[ADDR_W-1:0];
				if (is_push && sp_q < FULL) begin
					ram_we    = 1'b1;
					ram_waddr = sp_q[ADDR_W-1:0];
					ram_wdata = imm_q;
				end
			end
			S_RD_T: begin
				ram_raddr = sp_m2[ADDR_W-1:0];
				if (is_unary && op_q != OP_PRINT) begin
					ram_we    = 1'b1;
					ram_waddr = sp_m1[ADDR_W-1:0];
					ram_wdata = un_res;
				end
			end
			S_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = sp_m2[ADDR_W-1:0];
				ram_wdata = r_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			case (state_q)
				S_DECODE: begin
					if (is_push && sp_q < FULL) sp_q <= sp_q + CNT_W'(1);
				end
				S_RD_T: begin
					if (op_q == OP_PRINT) sp_q <= sp_m1;
				end
				S_WRITE: sp_q <= sp_m1;
				default: sp_q <= sp_q;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					op_q  <= cmd.op;
					imm_q <= cmd.imm_value;
				end
			end
			S_DECODE: begin
				pv_q     <= 1'b0;
				pval_q   <= '0;
				top_q    <= imm_q;
				if (is_push && sp_q >= FULL) status_q <= ST_OVER;
				else if (is_unary && sp_q < CNT_W'(1)) status_q <= ST_UNDER;
				else if (is_binary && sp_q < CNT_W'(2)) status_q <= ST_UNDER;
				else status_q <= ST_OK;
			end
			S_RD_T: begin
				t_q   <= ram_rdata;
				top_q <= un_res;
				if (op_q == OP_PRINT) begin
					pv_q   <= 1'b1;
					pval_q <= ram_rdata;
				end
			end
			S_RD_N: begin
				r_q   <= bin_res;
				top_q <= t_q;
				if (div_zero) status_q <= ST_DIVZ;
				// load the divider with magnitudes
				na_q  <= ram_rdata[W-1];
				dvd_q <= ram_rdata[W-1] ? ('0 - ram_rdata) : ram_rdata;
				rem_q <= '0;
				cnt_q <= '0;
				if (op_q == OP_NUMPERC) begin
					nb_q  <= 1'b0;
					dvs_q <= PERC_DIVISOR;
				end else begin
					nb_q  <= t_q[W-1];
					dvs_q <= t_q[W-1] ? ('0 - t_q) : t_q;
				end
			end
			S_DIV: begin
				rem_q <= q_bit ? trial[W-1:0] : {rem_q[W-2:0], dvd_q[W-1]};
				dvd_q <= {dvd_q[W-2:0], q_bit};
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			S_FIX: begin
				r_q <= (op_q == OP_MOD) ? r_fix : q_fix;
			end
			S_MUL: begin
				r_q <= mul_prod[W-1:0];
			end
			S_WRITE: begin
				top_q <= r_q;
			end
			S_TOPW: begin
				// new top after print, or unchanged top after a flagged step or an unknown code
				top_q <= (sp_q != '0) ? ram_rdata : '0;
			end
			default: begin
				top_q <= top_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			res_q.status      <= status_q;
			res_q.top_value   <= top_q;
			res_q.stack_count <= sp_q;
			res_q.print_valid <= pv_q;
			res_q.print_value <= pval_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	rse_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire

### sv/rse_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_ram - generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module rse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### sv/rse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_port_checks - port-level checks of the rpn stack evaluator
// word hold under stall on both channels and result word consistency
// ----------------------------------------------------------------------------
module rse_port_checks (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          cmd_valid,
	input wire logic          cmd_ready,
	input wire rse_pkg::cmd_t cmd,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire rse_pkg::res_t res
);

	import rse_pkg::*;

	// stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// offered instruction word holds until taken
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("instruction word changed while waiting");

	// empty stack reports a zero top
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.stack_count == '0 |-> res.top_value == '0)
		else $error("nonzero top on empty stack");

	// a printed word comes only from a good step
	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.print_valid |-> res.status == ST_OK
			&& res.stack_count < CNT_W'(STACK_DEPTH))
		else $error("print on flagged step");

	// no printed value without print
	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.print_valid |-> res.print_value == '0)
		else $error("print value without print");

endmodule

bind rpn_stack_evaluator rse_port_checks u_rse_port_checks (.*);
`default_nettype wire

### verif/rse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_checker - result checker of the rpn stack evaluator
// watches both channels, keeps its own copy of the stack, predicts one result
// word per accepted instruction and compares every field in order
// ----------------------------------------------------------------------------
module rse_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire logic           cmd_ready,
	input  wire rse_pkg::cmd_t  cmd,
	input  wire logic           res_valid,
	input  wire logic           res_ready,
	input  wire rse_pkg::res_t  res,
	input  wire logic           end_of_test,
	output int                  fail_count,
	output int                  pending
);

	import rse_pkg::*;

	localparam int MAX_PRINTED = 40;

	logic [DATA_WIDTH-1:0] stack_words [STACK_DEPTH];
	int unsigned           depth;
	res_t                  expected_words [$];

	int n_instr;
	int n_results;
	int n_under;
	int n_over;
	int n_divz;
	int n_prints;
	int max_depth;
	bit summary_done;

	initial begin
		fail_count   = 0;
		pending      = 0;
		depth        = 0;
		n_instr      = 0;
		n_results    = 0;
		n_under      = 0;
		n_over       = 0;
		n_divz       = 0;
		n_prints     = 0;
		max_depth    = 0;
		summary_done = 1'b0;
	end

	task automatic report(input string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("[%0t] error: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report($sformatf("result word %0d: %s is %h, expected %h",
				n_results, name, got, want));
	endtask

	// truncating signed divide, remainder takes the sign of the dividend
	function automatic logic [DATA_WIDTH-1:0] trunc_divide(
			input logic [DATA_WIDTH-1:0] a, input logic [DATA_WIDTH-1:0] b,
			input bit want_rem);
		logic [DATA_WIDTH-1:0] mag_a;
		logic [DATA_WIDTH-1:0] mag_b;
		logic [DATA_WIDTH-1:0] quo;
		logic [DATA_WIDTH-1:0] rem;
		mag_a = a[DATA_WIDTH-1] ? -a : a;
		mag_b = b[DATA_WIDTH-1] ? -b : b;
		quo   = mag_a / mag_b;
		rem   = mag_a % mag_b;
		if (want_rem)
			return a[DATA_WIDTH-1] ? -rem : rem;
		return (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -quo : quo;
	endfunction

	// applies one instruction to the local stack and returns the result word
	function automatic res_t eval_instruction(input cmd_t w);
		res_t                  r;
		logic [DATA_WIDTH-1:0] t;
		logic [DATA_WIDTH-1:0] n;
		logic [DATA_WIDTH-1:0] v;
		bit                    write_back;
		r          = '0;
		r.status   = ST_OK;
		write_back = 1'b1;
		case (w.op)
			OP_PUSH: begin
				if (depth >= STACK_DEPTH) begin
					r.status = ST_OVER;
				end else begin
					stack_words[depth] = w.imm_value;
					depth++;
				end
			end
			OP_NOT, OP_NEG, OP_TRIPLE, OP_PRINT: begin
				if (depth < 1) begin
					r.status = ST_UNDER;
				end else begin
					t = stack_words[depth-1];
					case (w.op)
						OP_PRINT: begin
							r.print_valid = 1'b1;
							r.print_value = t;
							depth--;
						end
						OP_NOT:  stack_words[depth-1] = DATA_WIDTH'(t == '0);
						OP_NEG:  stack_words[depth-1] = -t;
						default: stack_words[depth-1] = t * DATA_WIDTH'(3);
					endcase
				end
			end
			OP_PLUS, OP_MINUS, OP_MULT, OP_DIV, OP_MOD, OP_LESS, OP_GREATER,
			OP_EQUAL, OP_AND, OP_OR, OP_MAX, OP_MIN, OP_NUMPERC: begin
				if (depth < 2) begin
					r.status = ST_UNDER;
				end else begin
					t = stack_words[depth-1];
					n = stack_words[depth-2];
					v = '0;
					case (w.op)
						OP_PLUS:    v = n + t;
						OP_MINUS:   v = n - t;
						OP_MULT:    v = n * t;
						OP_DIV, OP_MOD: begin
							if (t == '0) begin
								r.status   = ST_DIVZ;
								write_back = 1'b0;
							end else begin
								v = trunc_divide(n, t, w.op == OP_MOD);
							end
						end
						OP_LESS:    v = DATA_WIDTH'($signed(n) < $signed(t));
						OP_GREATER: v = DATA_WIDTH'($signed(t) < $signed(n));
						OP_EQUAL:   v = DATA_WIDTH'(n == t);
						OP_AND:     v = DATA_WIDTH'((n != '0) && (t != '0));
						OP_OR:      v = DATA_WIDTH'((n != '0) || (t != '0));
						OP_MAX:     v = ($signed(n) < $signed(t)) ? t : n;
						OP_MIN:     v = ($signed(t) < $signed(n)) ? t : n;
						default:    v = trunc_divide(n, PERC_DIVISOR, 1'b0) * t;
					endcase
					if (write_back) begin
						stack_words[depth-2] = v;
						depth--;
					end
				end
			end
			default: ;
		endcase
		r.top_value   = (depth > 0) ? stack_words[depth-1] : '0;
		r.stack_count = CNT_W'(depth);
		return r;
	endfunction

	always @(posedge clk) begin
		res_t pred;
		res_t want;
		if (!arst_n) begin
			depth = 0;
			expected_words.delete();
		end else begin
			// instruction first, so a word accepted in the same cycle queues behind
			if (cmd_valid && cmd_ready) begin
				pred = eval_instruction(cmd);
				expected_words.push_back(pred);
				n_instr++;
				case (pred.status)
					ST_UNDER: n_under++;
					ST_OVER:  n_over++;
					ST_DIVZ:  n_divz++;
					default:  ;
				endcase
				if (pred.print_valid)
					n_prints++;
				if (depth > max_depth)
					max_depth = depth;
			end
			if (res_valid && res_ready) begin
				if (expected_words.size() == 0) begin
					report($sformatf("result word %0d arrived with nothing expected",
						n_results));
				end else begin
					want = expected_words.pop_front();
					check_field("status", res.status, want.status);
					check_field("top_value", res.top_value, want.top_value);
					check_field("stack_count", res.stack_count, want.stack_count);
					check_field("print_valid", res.print_valid, want.print_valid);
					check_field("print_value", res.print_value, want.print_value);
				end
				n_results++;
			end
			if (end_of_test && !summary_done) begin
				summary_done = 1'b1;
				if (expected_words.size() != 0)
					report($sformatf("%0d expected result words never arrived",
						expected_words.size()));
				$display("run covered %0d instructions and %0d result words: %0d underflow,",
					n_instr, n_results, n_under);
				$display("  %0d overflow, %0d divide by zero, %0d prints, deepest stack %0d",
					n_over, n_divz, n_prints, max_depth);
			end
		end
		pending <= expected_words.size();
	end

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top - testbench of the rpn stack evaluator
// drives a directed instruction list and then random instruction streams in
// bursts, stalls the result side on a pattern of its own, and leaves the
// prediction and comparison to rse_checker
// ----------------------------------------------------------------------------
module tb_top;

	import rse_pkg::*;

	localparam int RANDOM_WORDS = 2000;
	localparam int TAIL_CYCLES  = 64;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int OP_CODE_TOP  = (1 << OP_W) - 1;

	// extreme operands
	localparam logic signed [DATA_WIDTH-1:0] IMM_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] IMM_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_LONG_HOLD} rx_mode_e;

	logic clk         = 1'b0;
	logic arst_n      = 1'b0;
	logic cmd_valid   = 1'b0;
	logic res_ready   = 1'b0;
	logic end_of_test = 1'b0;
	cmd_t cmd         = '0;
	logic cmd_ready;
	logic res_valid;
	res_t res;
	int   fail_count;
	int   pending;
	int   cycle_count = 0;

	rpn_stack_evaluator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	rse_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.end_of_test (end_of_test),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog, sized far above the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rpn_stack_evaluator: mismatch");
			$finish;
		end
	end

	// offers one instruction word and holds it until the block takes it;
	// ready is read right after the edge, so it is the value the edge saw
	task automatic issue(input logic [OP_W-1:0] op,
			input logic signed [DATA_WIDTH-1:0] imm);
		cmd_t w;
		w.op        = op;
		w.imm_value = imm;
		cmd_valid <= 1'b1;
		cmd       <= w;
		do
			@(posedge clk);
		while (!cmd_ready);
	endtask

	// pauses the sender until every predicted result word has come back;
	// the first edge lets the checker count a word taken in this very cycle
	task automatic wait_for_drain();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// operands lean toward zero, one, minus one, the percent divisor and the extremes
	function automatic logic signed [DATA_WIDTH-1:0] random_operand();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 1;
			2:       return -1;
			3:       return IMM_MIN;
			4:       return IMM_MAX;
			5:       return PERC_DIVISOR;
			6:       return -PERC_DIVISOR;
			7:       return $urandom_range(0, 600) - 300;
			default: return $urandom;
		endcase
	endfunction

	// push with the given odds in percent, a few unknown codes, else any real op
	function automatic logic [OP_W-1:0] random_op(input int push_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			return OP_PUSH;
		if (roll >= 97)
			return OP_W'($urandom_range(OP_PRINT + 1, OP_CODE_TOP));
		return OP_W'($urandom_range(OP_PLUS, OP_PRINT));
	endfunction

	// result side: each stretch picks a stall pattern of its own
	initial begin : rx_pattern
		rx_mode_e mode;
		int       span;
		int       hold;
		hold = 0;
		forever begin
			mode = rx_mode_e'($urandom_range(0, 3));
			span = $urandom_range(32, 256);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					RX_STREAM: res_ready <= 1'b1;
					RX_COIN:   res_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: res_ready <= ($urandom_range(0, 5) == 0);
					default: begin
						// long holds, then one cycle of ready
						if (hold == 0) begin
							hold = $urandom_range(5, 40);
							res_ready <= 1'b1;
						end else begin
							hold--;
							res_ready <= 1'b0;
						end
					end
				endcase
			end
		end
	end

	initial begin : stimulus
		int sent;
		int burst_left;
		int gap;
		int seg_left;
		int push_pct;
		sent       = 0;
		burst_left = 0;
		seg_left   = 0;
		push_pct   = 45;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: underflow on an empty and a one-entry stack
		issue(OP_PRINT, $urandom);
		issue(OP_PUSH, IMM_MIN);
		issue(OP_PLUS, $urandom);
		// most negative over minus one, quotient and remainder
		issue(OP_PUSH, -1);
		issue(OP_DIV, $urandom);
		issue(OP_PUSH, -1);
		issue(OP_MOD, $urandom);
		// divide by zero leaves both entries in place
		issue(OP_PUSH, 0);
		issue(OP_DIV, $urandom);
		issue(OP_MOD, $urandom);
		issue(OP_EQUAL, $urandom);
		// wrap on plus, negate and triple of the most negative value
		issue(OP_PUSH, IMM_MAX);
		issue(OP_PLUS, $urandom);
		issue(OP_NEG, $urandom);
		issue(OP_TRIPLE, $urandom);
		issue(OP_NOT, $urandom);
		issue(OP_PUSH, IMM_MAX);
		issue(OP_MINUS, $urandom);
		issue(OP_PUSH, IMM_MAX);
		issue(OP_MULT, $urandom);
		// signed compares, logic ops, max and min across the sign boundary
		issue(OP_PUSH, -7);
		issue(OP_LESS, $urandom);
		issue(OP_PUSH, -5);
		issue(OP_GREATER, $urandom);
		issue(OP_PUSH, 0);
		issue(OP_AND, $urandom);
		issue(OP_PUSH, IMM_MIN);
		issue(OP_OR, $urandom);
		issue(OP_PUSH, IMM_MIN);
		issue(OP_MAX, $urandom);
		issue(OP_PUSH, IMM_MIN);
		issue(OP_MIN, $urandom);
		// percent op on a large negative next entry
		issue(OP_PUSH, -250);
		issue(OP_NUMPERC, $urandom);
		issue(OP_W'(OP_CODE_TOP), '1);
		issue(OP_PRINT, $urandom);

		// sender holds off until the block has answered everything
		wait_for_drain();

		// random part: segments bias the push rate so the stack fills up to
		// overflow, runs down to underflow, or wanders in between
		while (sent < RANDOM_WORDS) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(16, 64);
				case ($urandom_range(0, 9))
					0, 1, 2: push_pct = 75;
					3, 4:    push_pct = 20;
					default: push_pct = 45;
				endcase
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					cmd_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			if (sent == RANDOM_WORDS / 2)
				wait_for_drain();
			issue(random_op(push_pct), random_operand());
			sent++;
			burst_left--;
			seg_left--;
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		end_of_test <= 1'b1;
		repeat (3) @(posedge clk);
		if (fail_count == 0)
			$display("rpn_stack_evaluator: match");
		else
			$display("rpn_stack_evaluator: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
sv/rse_pkg.sv
sv/rse_ram.sv
sv/rpn_stack_evaluator.sv
sv/rse_checker.sv
verif/rse_checker.sv
verif/tb_top.sv
